>>> hdl/shfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_pkg
// Shared types, constants and the CRC-8 step for the serial HID frame receiver.
// ----------------------------------------------------------------------------
package shfr_pkg;

    localparam int PAYLOAD_MAX_DEF          = 16;
    localparam int KEY_REPORT_BYTES_DEF     = 8;
    localparam int POINTER_REPORT_BYTES_DEF = 7;

    localparam logic [7:0] FRAME_MAGIC  = 8'hAA;
    localparam logic [7:0] KIND_KEYS    = 8'h01;
    localparam logic [7:0] KIND_POINTER = 8'h02;
    localparam logic [7:0] KIND_RELEASE = 8'h03;
    localparam logic [7:0] CRC_START    = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h07;

    localparam logic REPORT_KEYBOARD = 1'b0;
    localparam logic REPORT_MOUSE    = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_kind;
        logic load_len;
        logic pay_wr;
        logic start_emit;
        logic emit_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_magic;
        logic len_ok;
        logic fill_last;
        logic emit_go;
        logic emit_last;
        logic out_free;
    } sts_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/shfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_if
// Valid/ready channels: received bytes in, report bytes out.
// ----------------------------------------------------------------------------
interface shfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       link_up;

    modport source (output valid, output rx_byte, output link_up, input ready);
    modport sink   (input valid, input rx_byte, input link_up, output ready);
endinterface

interface shfr_out_if;
    logic       valid;
    logic       ready;
    logic       report_kind;
    logic [7:0] report_byte;
    logic       last_byte;

    modport source (output valid, output report_kind, output report_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input report_kind, input report_byte,
                    input last_byte, output ready);
endinterface

>>> hdl/shfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/shfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_ctrl
// Frame parser and report replay state machine.
// ----------------------------------------------------------------------------
module shfr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output shfr_pkg::cmd_t cmd,
    input  shfr_pkg::sts_t sts
);

    typedef enum logic [6:0] {
        S_MAGIC   = 7'b0000001,
        S_TYPE    = 7'b0000010,
        S_LEN     = 7'b0000100,
        S_PAYLOAD = 7'b0001000,
        S_CRC     = 7'b0010000,
        S_RD      = 7'b0100000,
        S_WR      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg != S_RD) && (state_reg != S_WR);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_MAGIC:
            begin
                if (acc && sts.is_magic)
                    state_next = S_TYPE;
            end
            S_TYPE:
            begin
                if (acc)
                begin
                    cmd.load_kind = 1'b1;
                    state_next    = S_LEN;
                end
            end
            S_LEN:
            begin
                if (acc)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = S_PAYLOAD;
                    end
                    else
                        state_next = S_MAGIC;
                end
            end
            S_PAYLOAD:
            begin
                if (acc)
                begin
                    cmd.pay_wr = 1'b1;
                    if (sts.fill_last)
                        state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                if (acc)
                begin
                    if (sts.emit_go)
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = S_RD;
                    end
                    else
                        state_next = S_MAGIC;
                end
            end
            // address is presented here, RAM data is ready in S_WR
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? S_MAGIC : S_RD;
                end
            end
            default:
            begin
                state_next = S_MAGIC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_MAGIC;
        else
            state_reg <= state_next;
    end

    // a report starts only from the CRC beat and never overlaps input
    ap_emit_from_crc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_emit |=> (state_reg == S_RD) && !in_ready)
        else $error("report replay did not start after CRC beat");

    ap_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) && !$past(state_reg == S_WR) |-> $past(state_reg == S_RD))
        else $error("report byte loaded without a RAM read cycle");

endmodule

>>> hdl/shfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_dp
// Frame fields, CRC, payload store and report output register.
// ----------------------------------------------------------------------------
module shfr_dp #(
    parameter int PAYLOAD_MAX          = shfr_pkg::PAYLOAD_MAX_DEF,
    parameter int KEY_REPORT_BYTES     = shfr_pkg::KEY_REPORT_BYTES_DEF,
    parameter int POINTER_REPORT_BYTES = shfr_pkg::POINTER_REPORT_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  shfr_pkg::cmd_t cmd,
    output shfr_pkg::sts_t sts,
    input  logic [7:0]     rx_byte,
    input  logic           link_up,
    input  logic           out_ready,
    output logic           out_valid,
    output logic           out_kind,
    output logic [7:0]     out_byte,
    output logic           out_last
);

    localparam int RptMax = (KEY_REPORT_BYTES > POINTER_REPORT_BYTES) ?
                            KEY_REPORT_BYTES : POINTER_REPORT_BYTES;
    localparam int CntMax = (RptMax > PAYLOAD_MAX) ? RptMax : PAYLOAD_MAX;
    localparam int IDX_W  = $clog2(CntMax + 1);
    localparam int AW     = $clog2(PAYLOAD_MAX);

    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       crc_reg, crc_next;
    logic             zero_reg, zero_next;
    logic             ptr_reg, ptr_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       rd_data;
    logic [AW-1:0]    mem_addr;
    logic [IDX_W:0]   idx_inc;
    logic [IDX_W:0]   rpt_len;
    logic             is_release, keys_ok, ptr_ok;

    assign mem_addr = idx_reg[AW-1:0];
    assign idx_inc  = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign rpt_len  = ptr_reg ? (IDX_W+1)'(POINTER_REPORT_BYTES)
                              : (IDX_W+1)'(KEY_REPORT_BYTES);

    assign is_release = (kind_reg == shfr_pkg::KIND_RELEASE);
    assign keys_ok    = (kind_reg == shfr_pkg::KIND_KEYS) &&
                        (len_reg == 8'(KEY_REPORT_BYTES));
    assign ptr_ok     = (kind_reg == shfr_pkg::KIND_POINTER) &&
                        (len_reg == 8'(POINTER_REPORT_BYTES));

    shfr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.pay_wr),
        .wr_addr (mem_addr),
        .wr_data (rx_byte),
        .rd_addr (mem_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.is_magic  = (rx_byte == shfr_pkg::FRAME_MAGIC);
        sts.len_ok    = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= 9'(PAYLOAD_MAX));
        sts.fill_last = ({{(9 - IDX_W - 1){1'b0}}, idx_inc} >= {1'b0, len_reg});
        sts.emit_go   = (crc_reg == rx_byte) && link_up &&
                        (is_release || keys_ok || ptr_ok);
        sts.emit_last = (idx_inc == rpt_len);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        kind_next      = kind_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        zero_next      = zero_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (cmd.load_kind)
            kind_next = rx_byte;
        if (cmd.load_len)
        begin
            len_next = rx_byte;
            idx_next = '0;
            crc_next = shfr_pkg::CRC_START;
        end
        if (cmd.pay_wr)
        begin
            crc_next = shfr_pkg::crc8_byte(crc_reg, rx_byte);
            idx_next = idx_inc[IDX_W-1:0];
        end
        if (cmd.start_emit)
        begin
            idx_next  = '0;
            zero_next = is_release;
            ptr_next  = !is_release && ptr_ok;
        end
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = ptr_reg ? shfr_pkg::REPORT_MOUSE : shfr_pkg::REPORT_KEYBOARD;
            out_byte_next  = zero_reg ? 8'd0 : rd_data;
            out_last_next  = sts.emit_last;
            idx_next       = idx_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            crc_reg       <= shfr_pkg::CRC_START;
            zero_reg      <= 1'b0;
            ptr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            zero_reg      <= zero_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (!out_valid_reg || out_ready))
        else $error("report beat overwritten before it was taken");

    ap_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pay_wr |-> ({{(9 - IDX_W - 1){1'b0}}, idx_inc} <= {1'b0, len_reg}))
        else $error("payload write beyond frame length");

    ap_emit_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (idx_inc <= rpt_len))
        else $error("report byte index beyond report length");

endmodule

>>> hdl/serial_hid_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_hid_frame_receiver_unit
// Parses magic/type/length/payload/CRC-8 frames and replays HID reports.
// ----------------------------------------------------------------------------
// channel  modport  fields                                  beat
// in_ch    sink     rx_byte[7:0], link_up                   one received byte
// out_ch   source   report_kind, report_byte[7:0], last_byte one report byte
//
// While parsing, in_ch.ready stays high. After a good CRC beat on a valid
// report frame with link_up high, the input stalls while the report is
// replayed from the payload RAM: a RAM read, then an output register load for
// each report byte, the load waiting while out_ch holds off. The output register
// lets the next frame start while the final report beat still waits.
// Reset is asynchronous, active low; in_ch.ready is already high in reset, so
// the first edge after release can take a beat.
// ----------------------------------------------------------------------------
module serial_hid_frame_receiver_unit #(
    parameter int PAYLOAD_MAX          = shfr_pkg::PAYLOAD_MAX_DEF,
    parameter int KEY_REPORT_BYTES     = shfr_pkg::KEY_REPORT_BYTES_DEF,
    parameter int POINTER_REPORT_BYTES = shfr_pkg::POINTER_REPORT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    shfr_in_if.sink    in_ch,
    shfr_out_if.source out_ch
);

    shfr_pkg::cmd_t cmd;
    shfr_pkg::sts_t sts;

    shfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    shfr_dp #(
        .PAYLOAD_MAX          (PAYLOAD_MAX),
        .KEY_REPORT_BYTES     (KEY_REPORT_BYTES),
        .POINTER_REPORT_BYTES (POINTER_REPORT_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (in_ch.rx_byte),
        .link_up   (in_ch.link_up),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_kind  (out_ch.report_kind),
        .out_byte  (out_ch.report_byte),
        .out_last  (out_ch.last_byte)
    );

endmodule

>>> tb/shfr_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_report_checker
// Follows every accepted received byte through its own frame parser, queues
// the report beats each frame should produce, and compares them field by
// field with the beats taken from the output channel.
// ----------------------------------------------------------------------------
module shfr_report_checker (
    input  logic clk,
    input  logic rst_n,
    shfr_in_if   in_ch,
    shfr_out_if  out_ch,
    output int   mismatch_count,
    output int   reports_owed
);
    import shfr_pkg::*;

    localparam int PAYLOAD_MAX   = PAYLOAD_MAX_DEF;
    localparam int KEY_BYTES     = KEY_REPORT_BYTES_DEF;
    localparam int POINTER_BYTES = POINTER_REPORT_BYTES_DEF;

    typedef enum logic [2:0] {
        HUNT_MAGIC   = 3'd0,
        TAKE_KIND    = 3'd1,
        TAKE_LENGTH  = 3'd2,
        TAKE_PAYLOAD = 3'd3,
        TAKE_CRC     = 3'd4
    } parse_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } report_beat_t;

    parse_phase_t phase;
    logic [7:0]   frame_kind;
    logic [4:0]   frame_len;
    logic [4:0]   fill;
    logic [7:0]   crc_acc;
    logic [7:0]   payload [PAYLOAD_MAX];
    report_beat_t reports_due [$];

    function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_report(input logic kind, input logic [7:0] data, input logic last);
        report_beat_t beat;
        beat.kind = kind;
        beat.data = data;
        beat.last = last;
        reports_due.push_back(beat);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic link);
        case (phase)
            TAKE_KIND:
            begin
                frame_kind = b;
                phase      = TAKE_LENGTH;
            end
            TAKE_LENGTH:
            begin
                if (b == 8'd0 || b > PAYLOAD_MAX)
                    phase = HUNT_MAGIC;
                else
                begin
                    frame_len = b[4:0];
                    fill      = '0;
                    crc_acc   = CRC_START;
                    phase     = TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                payload[fill] = b;
                crc_acc       = crc_after(crc_acc, b);
                fill++;
                if (fill >= frame_len)
                    phase = TAKE_CRC;
            end
            TAKE_CRC:
            begin
                // link_up only matters on the CRC beat
                if (crc_acc == b && link)
                begin
                    if (frame_kind == KIND_RELEASE)
                    begin
                        for (int i = 0; i < KEY_BYTES; i++)
                            queue_report(REPORT_KEYBOARD, 8'h00, i == KEY_BYTES - 1);
                    end
                    else if (frame_kind == KIND_KEYS && frame_len == KEY_BYTES)
                    begin
                        for (int i = 0; i < KEY_BYTES; i++)
                            queue_report(REPORT_KEYBOARD, payload[i], i == KEY_BYTES - 1);
                    end
                    else if (frame_kind == KIND_POINTER && frame_len == POINTER_BYTES)
                    begin
                        for (int i = 0; i < POINTER_BYTES; i++)
                            queue_report(REPORT_MOUSE, payload[i], i == POINTER_BYTES - 1);
                    end
                end
                phase = HUNT_MAGIC;
            end
            default:
                phase = (b == FRAME_MAGIC) ? TAKE_KIND : HUNT_MAGIC;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_beat_t want;
        if (!rst_n)
        begin
            phase          = HUNT_MAGIC;
            frame_kind     = '0;
            frame_len      = '0;
            fill           = '0;
            crc_acc        = CRC_START;
            mismatch_count = 0;
            reports_owed   = 0;
            reports_due.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (reports_due.size() == 0)
                    report_mismatch($sformatf("unexpected report beat kind %0d byte %02h last %0d",
                                              out_ch.report_kind, out_ch.report_byte,
                                              out_ch.last_byte));
                else
                begin
                    want = reports_due.pop_front();
                    if (out_ch.report_kind !== want.kind)
                        report_mismatch($sformatf("report_kind got %0d, expected %0d",
                                                  out_ch.report_kind, want.kind));
                    if (out_ch.report_byte !== want.data)
                        report_mismatch($sformatf("report_byte got %02h, expected %02h",
                                                  out_ch.report_byte, want.data));
                    if (out_ch.last_byte !== want.last)
                        report_mismatch($sformatf("last_byte got %0d, expected %0d",
                                                  out_ch.last_byte, want.last));
                end
            end
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.rx_byte, in_ch.link_up);
            reports_owed = reports_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the serial HID frame receiver with directed and random byte streams:
// well-formed keyboard, mouse and release frames, plus bad lengths, bad CRCs,
// link-down frames and line noise, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import shfr_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_BEATS    = 300;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef logic [7:0] byte_q_t [$];

    logic clk = 1'b0;
    logic rst_n;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_cycles = 0;
    int   beats_sent  = 0;
    int   cycle_count = 0;
    int   mismatch_count;
    int   reports_owed;

    shfr_in_if  in_ch ();
    shfr_out_if out_ch ();

    serial_hid_frame_receiver_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    shfr_report_checker report_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // report sink: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic byte_q_t random_payload(input int n);
        byte_q_t q;
        repeat (n)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // called and returns at a falling edge; one beat per call
    task automatic send_beat(input logic [7:0] b, input logic link);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.link_up <= link;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] kind, input logic [7:0] len_field,
                              input byte_q_t pay, input bit crc_ok, input logic link);
        logic [7:0] crc;
        crc = CRC_START;
        send_beat(FRAME_MAGIC, 1'($urandom));
        send_beat(kind, 1'($urandom));
        send_beat(len_field, 1'($urandom));
        if (len_field == 8'd0 || len_field > PAYLOAD_MAX_DEF)
            return;
        foreach (pay[i])
        begin
            send_beat(pay[i], 1'($urandom));
            crc = crc8_byte(crc, pay[i]);
        end
        if (!crc_ok)
            crc ^= 8'($urandom_range(1, 255));
        send_beat(crc, link);
    endtask

    task automatic send_random_frame();
        int         pick;
        int         n;
        logic [7:0] kind;
        pick = $urandom_range(99);
        n    = ($urandom_range(3) == 0) ? PAYLOAD_MAX_DEF : $urandom_range(1, 8);
        case ($urandom_range(2))
            0:       kind = KIND_KEYS;
            1:       kind = KIND_POINTER;
            default: kind = KIND_RELEASE;
        endcase
        // broken frames keep the report length so only the fault drops them
        if (pick >= 70)
        begin
            if (kind == KIND_KEYS)
                n = KEY_REPORT_BYTES_DEF;
            else if (kind == KIND_POINTER)
                n = POINTER_REPORT_BYTES_DEF;
        end
        if (pick < 30)
            send_frame(KIND_KEYS, 8'(KEY_REPORT_BYTES_DEF),
                       random_payload(KEY_REPORT_BYTES_DEF), 1'b1, 1'b1);
        else if (pick < 50)
            send_frame(KIND_POINTER, 8'(POINTER_REPORT_BYTES_DEF),
                       random_payload(POINTER_REPORT_BYTES_DEF), 1'b1, 1'b1);
        else if (pick < 62)
            send_frame(KIND_RELEASE, 8'(n), random_payload(n), 1'b1, 1'b1);
        else if (pick < 70)
            send_frame(8'($urandom), 8'(n), random_payload(n), 1'b1, 1'b1);
        else if (pick < 78)
            send_frame(kind, 8'(n), random_payload(n), 1'b0, 1'b1);
        else if (pick < 85)
            send_frame(kind, 8'(n), random_payload(n), 1'b1, 1'b0);
        else if (pick < 92)
            send_frame(kind, ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(17, 255)),
                       random_payload(0), 1'b1, 1'b1);
        else
            repeat ($urandom_range(1, 4))
                send_beat(8'($urandom), 1'($urandom));
    endtask

    // sender goes quiet until every owed report beat has been taken
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (reports_owed != 0)
            @(negedge clk);
    endtask

    initial
    begin
        byte_q_t keys_extreme;
        int      target;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.link_up = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 13;
        rx_idle_pct = 76;

        // stray bytes while hunting for magic
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        keys_extreme = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE};
        send_frame(KIND_KEYS, 8'(KEY_REPORT_BYTES_DEF), keys_extreme, 1'b1, 1'b1);
        send_frame(KIND_POINTER, 8'(POINTER_REPORT_BYTES_DEF),
                   random_payload(POINTER_REPORT_BYTES_DEF), 1'b1, 1'b1);
        send_frame(KIND_RELEASE, 8'd1, random_payload(1), 1'b1, 1'b1);
        // zero length and one past the payload limit
        send_frame(KIND_KEYS, 8'd0, random_payload(0), 1'b1, 1'b1);
        send_frame(KIND_KEYS, 8'(PAYLOAD_MAX_DEF + 1), random_payload(0), 1'b1, 1'b1);

        for (int pass_idx = 0; pass_idx < 3; pass_idx++)
        begin
            case (pass_idx)
                0:
                begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 76;
                end
                1:
                begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 13;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // sink holds off while keyboard frames keep coming in
                    hold_cycles = HOLD_OFF_CYCLES;
                    repeat (3)
                        send_frame(KIND_KEYS, 8'(KEY_REPORT_BYTES_DEF),
                                   random_payload(KEY_REPORT_BYTES_DEF), 1'b1, 1'b1);
                end
            endcase
            target = beats_sent + RANDOM_BEATS / 3;
            while (beats_sent < target)
                send_random_frame();
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
